// ===== rtl/csgt_pkg.sv =====
// Shared types and constants for the clock-synced gate toggle with fade.
// Holds the transaction payload structs, register map and divider interface.
// No dependencies.
`default_nettype none

package csgt_pkg;

   localparam int CHANNELS     = 8;
   localparam int SAMPLE_WIDTH = 16;
   localparam int CH_W         = 3;
   localparam int CH_IDX_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int LEVEL_W      = 25;
   localparam int LEVEL_FRAC   = 24;
   localparam int TICKS_W      = 24;
   localparam int MASK_W       = 8;
   localparam int CSR_ADDR_W   = 4;
   localparam int CSR_DATA_W   = 32;

   localparam logic [LEVEL_W-1:0] LEVEL_ONE = LEVEL_W'(1) << LEVEL_FRAC;

   // register indexes (byte address / 4)
   localparam logic [1:0] REG_FADE_TICKS    = 2'd0;
   localparam logic [1:0] REG_DISABLE_UNARM = 2'd1;
   localparam logic [1:0] REG_INPUT_MASK    = 2'd2;

   typedef struct packed {
      logic [CH_W-1:0]                channel;
      logic                           clock_level;
      logic                           reset_all_level;
      logic                           arm_level;
      logic                           reset_level;
      logic signed [SAMPLE_WIDTH-1:0] in_sample;
   } req_type;

   typedef struct packed {
      logic [CH_W-1:0]                out_channel;
      logic                           gate;
      logic                           warn;
      logic [LEVEL_W-1:0]             fade_level_out;
      logic signed [SAMPLE_WIDTH-1:0] out_sample;
   } rsp_type;

   typedef struct packed {
      logic               start;
      logic [LEVEL_W-1:0] num;
      logic [TICKS_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic               busy;
      logic               done;
      logic [LEVEL_W-1:0] quot;
   } div_rsp_type;

endpackage

`default_nettype wire

// ===== rtl/csgt_div.sv =====
// Bit-serial restoring divider giving ceil(num / den), one quotient bit a cycle.
// Depends on csgt_pkg for widths and the request/response structs.
`default_nettype none

module csgt_div (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire csgt_pkg::div_req_type div_req,
   output csgt_pkg::div_rsp_type      div_rsp
);
   import csgt_pkg::*;

   localparam int CNT_W = $clog2(LEVEL_W);

   logic               busy_ff;
   logic               done_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic [TICKS_W-1:0] rem_ff;
   logic [LEVEL_W-1:0] quo_ff;
   logic [TICKS_W-1:0] den_ff;

   logic [TICKS_W:0]   shift_rem;
   logic               fits;
   logic [TICKS_W:0]   diff;

   always_comb begin
      shift_rem = {rem_ff, quo_ff[LEVEL_W-1]};
      fits      = shift_rem >= {1'b0, den_ff};
      diff      = shift_rem - {1'b0, den_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (div_req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            rem_ff  <= '0;
            quo_ff  <= div_req.num;
            den_ff  <= div_req.den;
         end else if (busy_ff) begin
            rem_ff <= fits ? diff[TICKS_W-1:0] : shift_rem[TICKS_W-1:0];
            quo_ff <= {quo_ff[LEVEL_W-2:0], fits};
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(LEVEL_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // round up when a remainder is left
   assign div_rsp.busy = busy_ff;
   assign div_rsp.done = done_ff;
   assign div_rsp.quot = quo_ff + LEVEL_W'(rem_ff != '0);

endmodule

`default_nettype wire

// ===== rtl/clock_synced_gate_toggle_with_fade.sv =====
// Top level of the clock-synced gate toggle with linear fade.
// Depends on csgt_pkg and csgt_div; per-channel state lives in a local RAM.
`default_nettype none

// Channel   Ports                               Direction  Moves
// request   req_valid/req_stall/req_data        in         one item per channel slot
// response  rsp_valid/rsp_stall/rsp_data        out        one result per item
// config    psel/penable/pwrite/paddr/pwdata    in         register writes, prdata reads
//
// An item goes from acceptance through the evaluate, update, multiply and output
// states to the result register; when a fade with nonzero fade_ticks starts, the
// serial divider computing the fade step runs between evaluate and update. One
// item is in work at a time: the next is taken once the previous result is loaded.
// Synchronous reset clears the controller, frame edge flags and per-channel valid
// bits; an entry never written since reset reads as idle with zero fade.
// A stalled result holds in its output register while the next item is taken.

module clock_synced_gate_toggle_with_fade (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire csgt_pkg::req_type                 req_data,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output csgt_pkg::rsp_type                      rsp_data,
   input  wire logic                              psel,
   input  wire logic                              penable,
   input  wire logic                              pwrite,
   input  wire logic [csgt_pkg::CSR_ADDR_W-1:0]   paddr,
   input  wire logic [csgt_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [csgt_pkg::CSR_DATA_W-1:0]        prdata,
   output logic                                   pready
);
   import csgt_pkg::*;

   localparam int PROD_W = SAMPLE_WIDTH + LEVEL_W;

   typedef enum logic [1:0] {
      MODE_IDLE, MODE_WAIT_GATE, MODE_GATING, MODE_WAIT_IDLE
   } mode_type;

   typedef enum logic [1:0] {
      PH_STOPPED, PH_RISING, PH_HELD, PH_FALLING
   } phase_type;

   typedef struct packed {
      mode_type           mode;
      logic               prev_arm;
      logic               prev_rst;
      phase_type          phase;
      logic [LEVEL_W-1:0] level;
      logic [LEVEL_W-1:0] step;
   } chan_state_type;

   typedef enum logic [2:0] {
      S_IDLE, S_EVAL, S_DIV, S_UPD, S_MUL, S_OUT
   } state_type;

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   logic [TICKS_W-1:0] fade_ticks_ff;
   logic               disable_unarm_ff;
   logic [MASK_W-1:0]  input_mask_ff;
   logic               csr_write;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         fade_ticks_ff    <= '0;
         disable_unarm_ff <= 1'b0;
         input_mask_ff    <= '0;
      end else if (csr_write) begin
         case (paddr[3:2])
            REG_FADE_TICKS:    fade_ticks_ff    <= pwdata[TICKS_W-1:0];
            REG_DISABLE_UNARM: disable_unarm_ff <= pwdata[0];
            REG_INPUT_MASK:    input_mask_ff    <= pwdata[MASK_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         REG_FADE_TICKS:    prdata = CSR_DATA_W'(fade_ticks_ff);
         REG_DISABLE_UNARM: prdata = CSR_DATA_W'(disable_unarm_ff);
         REG_INPUT_MASK:    prdata = CSR_DATA_W'(input_mask_ff);
         default:           prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------------
   // Controller registers
   // ---------------------------------------------------------------------
   state_type            state_ff;
   req_type              item_ff;
   logic                 oor_ff;           // channel slot beyond CHANNELS
   logic                 frame_clk_edge_ff;
   logic                 frame_rsa_edge_ff;
   logic                 prev_clock_ff;
   logic                 prev_rsa_ff;
   logic [CHANNELS-1:0]  vld_ff;
   logic                 rd_vld_ff;
   chan_state_type       rd_ff;
   chan_state_type       wk_ff;
   logic [LEVEL_W-1:0]   lvl_ff;
   logic                 gate_ff;
   logic                 warn_ff;
   logic [PROD_W-1:0]    prod_ff;
   logic                 neg_ff;
   logic                 rsp_valid_ff;
   rsp_type              rsp_ff;

   logic                 req_accept;
   logic [CH_IDX_W-1:0]  acc_idx;
   logic [CH_IDX_W-1:0]  item_idx;
   logic                 mem_we;
   chan_state_type       mem [CHANNELS];

   div_req_type          div_req;
   div_rsp_type          div_rsp;

   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign acc_idx    = req_data.channel[CH_IDX_W-1:0];
   assign item_idx   = item_ff.channel[CH_IDX_W-1:0];

   // ---------------------------------------------------------------------
   // Evaluate resets, arm edge and mode change on the state read from RAM
   // ---------------------------------------------------------------------
   chan_state_type ev_state;
   logic           ev_need_div;
   logic [LEVEL_W-1:0] ev_num;
   chan_state_type s_cur;
   logic           arm_edge;
   logic           cancel;

   always_comb begin
      s_cur       = rd_vld_ff ? rd_ff : chan_state_type'('0);
      ev_state    = s_cur;
      ev_need_div = 1'b0;
      ev_num      = '0;

      // frame reset-all first, then the channel's own reset edge
      if (frame_rsa_edge_ff || (item_ff.reset_level && !s_cur.prev_rst)) begin
         ev_state.mode  = MODE_IDLE;
         ev_state.phase = PH_STOPPED;
         ev_state.level = '0;
      end
      ev_state.prev_rst = item_ff.reset_level;

      arm_edge          = item_ff.arm_level && !s_cur.prev_arm;
      ev_state.prev_arm = item_ff.arm_level;
      cancel            = arm_edge && !disable_unarm_ff;

      case (ev_state.mode)
         MODE_IDLE: begin
            if (arm_edge) ev_state.mode = MODE_WAIT_GATE;
         end
         MODE_WAIT_GATE: begin
            if (cancel) begin
               ev_state.mode = MODE_IDLE;
            end else if (frame_clk_edge_ff) begin
               ev_state.mode = MODE_GATING;
               if (fade_ticks_ff == '0) begin
                  ev_state.phase = PH_HELD;
                  ev_state.level = LEVEL_ONE;
               end else begin
                  ev_state.phase = PH_RISING;
                  ev_need_div    = 1'b1;
                  ev_num         = LEVEL_ONE - ev_state.level;
               end
            end
         end
         MODE_GATING: begin
            if (arm_edge) ev_state.mode = MODE_WAIT_IDLE;
         end
         MODE_WAIT_IDLE: begin
            if (cancel) begin
               ev_state.mode = MODE_GATING;
            end else if (frame_clk_edge_ff) begin
               ev_state.mode = MODE_IDLE;
               if (fade_ticks_ff == '0) begin
                  ev_state.phase = PH_STOPPED;
                  ev_state.level = '0;
               end else begin
                  ev_state.phase = PH_FALLING;
                  ev_need_div    = 1'b1;
                  ev_num         = ev_state.level;
               end
            end
         end
         default: ;
      endcase
   end

   assign div_req.start = (state_ff == S_EVAL) && !oor_ff && ev_need_div;
   assign div_req.num   = ev_num;
   assign div_req.den   = fade_ticks_ff;

   csgt_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // ---------------------------------------------------------------------
   // Advance the fade by one tick
   // ---------------------------------------------------------------------
   chan_state_type   up_state;
   logic [LEVEL_W:0] rise_sum;

   always_comb begin
      up_state = wk_ff;
      rise_sum = {1'b0, wk_ff.level} + {1'b0, wk_ff.step};
      case (wk_ff.phase)
         PH_RISING: begin
            if (rise_sum >= {1'b0, LEVEL_ONE}) begin
               up_state.phase = PH_HELD;
               up_state.level = LEVEL_ONE;
            end else begin
               up_state.level = rise_sum[LEVEL_W-1:0];
            end
         end
         PH_FALLING: begin
            if (wk_ff.step > wk_ff.level) begin
               up_state.phase = PH_STOPPED;
               up_state.level = '0;
            end else begin
               up_state.level = wk_ff.level - wk_ff.step;
            end
         end
         default: ;
      endcase
   end

   assign mem_we = (state_ff == S_UPD);

   // ---------------------------------------------------------------------
   // Source magnitude and output sign
   // ---------------------------------------------------------------------
   logic                    src_neg;
   logic [SAMPLE_WIDTH-1:0] src_mag;
   logic [PROD_W-1:0]       prod_in;
   logic [SAMPLE_WIDTH-1:0] mag;
   logic [SAMPLE_WIDTH-1:0] out_bits;

   always_comb begin
      if (input_mask_ff[item_ff.channel]) begin
         src_neg = item_ff.in_sample[SAMPLE_WIDTH-1];
         src_mag = src_neg ? (~item_ff.in_sample + 1'b1) : item_ff.in_sample;
      end else begin
         src_neg = 1'b0;
         src_mag = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};   // positive full scale
      end
      prod_in  = PROD_W'(src_mag) * PROD_W'(lvl_ff);
      mag      = prod_ff[LEVEL_FRAC +: SAMPLE_WIDTH];
      out_bits = neg_ff ? (~mag + 1'b1) : mag;
   end

   // ---------------------------------------------------------------------
   // Per-channel state RAM: read at acceptance, write back after the update
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (req_accept) rd_ff <= mem[acc_idx];
      if (mem_we)     mem[item_idx] <= up_state;
   end

   // ---------------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= S_IDLE;
         rsp_valid_ff      <= 1'b0;
         vld_ff            <= '0;
         prev_clock_ff     <= 1'b0;
         prev_rsa_ff       <= 1'b0;
         frame_clk_edge_ff <= 1'b0;
         frame_rsa_edge_ff <= 1'b0;
      end else begin
         // drop the result once taken, unless a new one is loaded now
         if (rsp_valid_ff && !rsp_stall && (state_ff != S_OUT)) rsp_valid_ff <= 1'b0;

         case (state_ff)
            S_IDLE: begin
               if (req_accept) begin
                  item_ff   <= req_data;
                  oor_ff    <= {1'b0, req_data.channel} >= (CH_W+1)'(CHANNELS);
                  rd_vld_ff <= vld_ff[acc_idx];
                  // a channel-0 item opens a frame and samples the shared levels
                  if (req_data.channel == '0) begin
                     frame_clk_edge_ff <= req_data.clock_level && !prev_clock_ff;
                     frame_rsa_edge_ff <= req_data.reset_all_level && !prev_rsa_ff;
                     prev_clock_ff     <= req_data.clock_level;
                     prev_rsa_ff       <= req_data.reset_all_level;
                  end
                  state_ff <= S_EVAL;
               end
            end
            S_EVAL: begin
               wk_ff <= ev_state;
               if (oor_ff) begin
                  lvl_ff   <= '0;
                  gate_ff  <= 1'b0;
                  warn_ff  <= 1'b0;
                  state_ff <= S_MUL;
               end else if (ev_need_div) begin
                  state_ff <= S_DIV;
               end else begin
                  state_ff <= S_UPD;
               end
            end
            S_DIV: begin
               if (div_rsp.done) begin
                  wk_ff.step <= div_rsp.quot;
                  state_ff   <= S_UPD;
               end
            end
            S_UPD: begin
               vld_ff[item_idx] <= 1'b1;
               lvl_ff   <= up_state.level;
               gate_ff  <= (up_state.mode == MODE_GATING) ||
                           (up_state.mode == MODE_WAIT_IDLE);
               warn_ff  <= (up_state.mode == MODE_WAIT_GATE) ||
                           (up_state.mode == MODE_WAIT_IDLE);
               state_ff <= S_MUL;
            end
            S_MUL: begin
               prod_ff  <= prod_in;
               neg_ff   <= src_neg && !oor_ff;
               state_ff <= S_OUT;
            end
            S_OUT: begin
               // load the output register once it is free or being emptied
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_ff.out_channel    <= item_ff.channel;
                  rsp_ff.gate           <= gate_ff;
                  rsp_ff.warn           <= warn_ff;
                  rsp_ff.fade_level_out <= lvl_ff;
                  rsp_ff.out_sample     <= $signed(out_bits);
                  rsp_valid_ff          <= 1'b1;
                  state_ff              <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   a_accept_to_eval: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff == S_EVAL))
      else $error("accepted transaction did not move to evaluation");

   a_div_running: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (div_rsp.busy || div_rsp.done))
      else $error("waiting on divider that is not running");

   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MUL) |-> (lvl_ff <= LEVEL_ONE))
      else $error("fade level above one");

   a_div_idle_start: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !div_rsp.busy)
      else $error("divider started while busy");

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
// Self-checking testbench for clock_synced_gate_toggle_with_fade.
// Holds the stimulus, an in-line toggle/fade predictor and the result checker.
// Depends on csgt_pkg and the block's RTL only.
`default_nettype none

module tb_top;
   import csgt_pkg::*;

   // Toggle and fade encodings of the predictor (the block keeps its own)
   typedef enum logic [1:0] {TOG_IDLE, TOG_WAIT_GATE, TOG_GATING, TOG_WAIT_IDLE} tog_mode_type;
   typedef enum logic [1:0] {FADE_STOPPED, FADE_RISING, FADE_HELD, FADE_FALLING} fade_phase_type;

   localparam int unsigned ONE_Q24        = 32'd1 << LEVEL_FRAC;
   localparam int unsigned FULL_SCALE     = (32'd1 << (SAMPLE_WIDTH - 1)) - 1;
   // slowest item is one where a fade step is divided out; leave margin
   localparam int          SETTLE_CYCLES  = 40;
   localparam int          RANDOM_PHASES  = 8;
   localparam int          ITEMS_PER_PHASE = 50;
   localparam int          DIRECTED_ROWS  = 25;
   localparam int          DIRECTED_SPLIT = 14;
   // bound for ~460 items, each with a fade step divided out at worst plus long gap
   // and stall tails, plus nine register phases
   localparam int          WATCHDOG_TIME  = 4_000_000;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_data;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   clock_synced_gate_toggle_with_fade i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Predictor state: one copy of the block's registers and channel RAM
   // ------------------------------------------------------------------
   int unsigned      fade_ticks_cfg = 0;
   logic             unarm_cfg      = 1'b0;
   logic [MASK_W-1:0] mask_cfg      = '0;

   tog_mode_type   ch_mode       [CHANNELS] = '{default: TOG_IDLE};
   fade_phase_type ch_fade       [CHANNELS] = '{default: FADE_STOPPED};
   int unsigned ch_level      [CHANNELS] = '{default: 0};
   int unsigned ch_delta      [CHANNELS] = '{default: 0};
   logic        ch_arm_seen   [CHANNELS] = '{default: 1'b0};
   logic        ch_reset_seen [CHANNELS] = '{default: 1'b0};
   logic        prev_clk  = 1'b0;
   logic        prev_rsa  = 1'b0;
   logic        clk_edge  = 1'b0;
   logic        rsa_edge  = 1'b0;

   rsp_type expected_results[$];
   rsp_type want_rsp;
   int      failures        = 0;
   int      sent_count      = 0;
   int      results_checked = 0;
   int      send_gap_pct    = 0;
   int      stall_pct       = 0;

   function automatic logic coin(input int pct);
      return $urandom_range(0, 99) < pct;
   endfunction

   // Advance the toggle and fade of one channel for one transaction and
   // return the result the block must produce for it.
   function automatic rsp_type toggle_and_fade(input req_type r);
      rsp_type                 res;
      logic [CH_IDX_W-1:0]     c;
      logic                    arm_edge;
      logic                    neg;
      logic [SAMPLE_WIDTH-1:0] raw;
      logic [SAMPLE_WIDTH-1:0] raw_abs;
      logic [SAMPLE_WIDTH-1:0] prod_lo;
      int unsigned             src_mag;
      longint unsigned         prod;
      res = '0;
      c = r.channel[CH_IDX_W-1:0];
      res.out_channel = r.channel;

      // frame edges are latched on the channel-0 slot and hold for the frame
      if (r.channel == '0) begin
         clk_edge = r.clock_level && !prev_clk;
         rsa_edge = r.reset_all_level && !prev_rsa;
         prev_clk = r.clock_level;
         prev_rsa = r.reset_all_level;
      end
      if (32'(r.channel) >= CHANNELS) return res;

      // reset-all edge and the channel's own reset edge both drop to idle
      if (rsa_edge || (r.reset_level && !ch_reset_seen[c])) begin
         ch_mode[c]  = TOG_IDLE;
         ch_fade[c]  = FADE_STOPPED;
         ch_level[c] = 0;
      end
      ch_reset_seen[c] = r.reset_level;

      arm_edge = r.arm_level && !ch_arm_seen[c];
      ch_arm_seen[c] = r.arm_level;

      case (ch_mode[c])
         TOG_IDLE: begin
            if (arm_edge) ch_mode[c] = TOG_WAIT_GATE;
         end
         TOG_WAIT_GATE: begin
            if (arm_edge && !unarm_cfg) begin
               ch_mode[c] = TOG_IDLE;
            end else if (clk_edge) begin
               ch_mode[c] = TOG_GATING;
               if (fade_ticks_cfg == 0) begin
                  ch_fade[c]  = FADE_HELD;
                  ch_level[c] = ONE_Q24;
               end else begin
                  ch_fade[c]  = FADE_RISING;
                  ch_delta[c] = (ONE_Q24 - ch_level[c] + fade_ticks_cfg - 1) / fade_ticks_cfg;
               end
            end
         end
         TOG_GATING: begin
            if (arm_edge) ch_mode[c] = TOG_WAIT_IDLE;
         end
         default: begin
            if (arm_edge && !unarm_cfg) begin
               ch_mode[c] = TOG_GATING;
            end else if (clk_edge) begin
               ch_mode[c] = TOG_IDLE;
               if (fade_ticks_cfg == 0) begin
                  ch_fade[c]  = FADE_STOPPED;
                  ch_level[c] = 0;
               end else begin
                  ch_fade[c]  = FADE_FALLING;
                  ch_delta[c] = (ch_level[c] + fade_ticks_cfg - 1) / fade_ticks_cfg;
               end
            end
         end
      endcase

      // level moves in the same tick as the mode change
      if (ch_fade[c] == FADE_RISING) begin
         ch_level[c] += ch_delta[c];
         if (ch_level[c] >= ONE_Q24) begin
            ch_fade[c]  = FADE_HELD;
            ch_level[c] = ONE_Q24;
         end
      end else if (ch_fade[c] == FADE_FALLING) begin
         if (ch_delta[c] > ch_level[c]) begin
            ch_fade[c]  = FADE_STOPPED;
            ch_level[c] = 0;
         end else begin
            ch_level[c] -= ch_delta[c];
         end
      end

      // unconnected input plays positive full scale
      raw = r.in_sample;
      raw_abs = ~raw + 1'b1;
      if (mask_cfg[c]) begin
         neg = raw[SAMPLE_WIDTH-1];
         src_mag = neg ? 32'(raw_abs) : 32'(raw);
      end else begin
         neg = 1'b0;
         src_mag = FULL_SCALE;
      end
      prod = (64'(src_mag) * 64'(ch_level[c])) >> LEVEL_FRAC;
      prod_lo = prod[SAMPLE_WIDTH-1:0];

      res.gate           = (ch_mode[c] == TOG_GATING) || (ch_mode[c] == TOG_WAIT_IDLE);
      res.warn           = (ch_mode[c] == TOG_WAIT_GATE) || (ch_mode[c] == TOG_WAIT_IDLE);
      res.fade_level_out = LEVEL_W'(ch_level[c]);
      res.out_sample     = neg ? ~prod_lo + 1'b1 : prod_lo;
      return res;
   endfunction

   function automatic logic signed [SAMPLE_WIDTH-1:0] pick_sample();
      logic [SAMPLE_WIDTH-1:0] s;
      s = SAMPLE_WIDTH'($urandom);
      // lean on the extremes: most negative, most positive, zero, minus one
      case ($urandom_range(0, 7))
         0: s = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
         1: s = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
         2: s = '0;
         3: s = '1;
         default: ;
      endcase
      return s;
   endfunction

   // ------------------------------------------------------------------
   // Request side. Tasks enter and leave at a falling edge; payload and
   // valid only change there, and acceptance is seen at the rising edge.
   // ------------------------------------------------------------------
   task automatic offer(input req_type item, input logic typed, input rsp_type want);
      rsp_type pred;
      // idle the request channel for a random gap
      while (coin(send_gap_pct)) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      // transaction accepted: always advance the predictor, even when the
      // directed table supplies the expected result itself
      pred = toggle_and_fade(item);
      expected_results.push_back(typed ? want : pred);
      sent_count++;
      @(negedge clock);
   endtask

   // Drop valid and drain: every transaction yields a result, so an empty
   // queue plus the slowest item's latency means the block is idle.
   task automatic settle();
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_access(input logic wr, input logic [1:0] idx,
                             input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= wr;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (!wr && prdata !== value) begin
         $display("%0t: register %0d readback expected %0h, got %0h", $time, idx, value, prdata);
         failures++;
      end
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic csr_store(input logic [1:0] idx, input logic [CSR_DATA_W-1:0] value);
      csr_access(1'b1, idx, value);
      csr_access(1'b0, idx, value);
   endtask

   task automatic program_csr(input logic [TICKS_W-1:0] fade, input logic unarm,
                              input logic [MASK_W-1:0] mask);
      settle();
      csr_store(REG_FADE_TICKS, 32'(fade));
      csr_store(REG_DISABLE_UNARM, 32'(unarm));
      csr_store(REG_INPUT_MASK, 32'(mask));
      fade_ticks_cfg = 32'(fade);
      unarm_cfg      = unarm;
      mask_cfg       = mask;
   endtask

   // ------------------------------------------------------------------
   // Result side: random stall, compare each transaction with the oldest
   // expectation.
   // ------------------------------------------------------------------
   always @(negedge clock) rsp_stall <= coin(stall_pct);

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            $display("%0t: result with nothing expected: %p", $time, rsp_data);
            failures++;
         end else begin
            want_rsp = expected_results.pop_front();
            results_checked++;
            if (rsp_data !== want_rsp) begin
               $display("%0t: mismatch expected ch %0d gate %0b warn %0b level %0d sample %0d",
                        $time, want_rsp.out_channel, want_rsp.gate, want_rsp.warn,
                        want_rsp.fade_level_out, want_rsp.out_sample);
               $display("%0t:          actual   ch %0d gate %0b warn %0b level %0d sample %0d",
                        $time, rsp_data.out_channel, rsp_data.gate, rsp_data.warn,
                        rsp_data.fade_level_out, rsp_data.out_sample);
               failures++;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Directed table. Rows before DIRECTED_SPLIT run with the reset register
   // values (instant switching, all inputs unconnected); the rest run with a
   // four-tick fade, unarm disabled and every input connected. A typed
   // result is given only where it follows directly from reset or the
   // instant-switching extremes; all other rows use the predictor.
   // ------------------------------------------------------------------
   typedef struct packed {
      req_type item;
      logic    typed;
      rsp_type want;
   } dir_row_type;

   //  item: ch, clk, rsa, arm, rst, sample       typed  want: ch, gate, warn, level, sample
   dir_row_type directed_rows [DIRECTED_ROWS] = '{
      // first slot after reset: idle, silent
      '{'{3'd0, 1'b0, 1'b0, 1'b0, 1'b0, 16'sh0000}, 1'b1, '{3'd0, 1'b0, 1'b0, 25'd0, 16'sh0000}},
      // arm edge: waiting for a clock edge
      '{'{3'd0, 1'b0, 1'b0, 1'b1, 1'b0, 16'sh0000}, 1'b1, '{3'd0, 1'b0, 1'b1, 25'd0, 16'sh0000}},
      // clock edge, zero fade: full level, unconnected input gives full scale
      '{'{3'd0, 1'b1, 1'b0, 1'b1, 1'b0, 16'sh0000}, 1'b1,
        '{3'd0, 1'b1, 1'b0, 25'd16777216, 16'sh7FFF}},
      '{'{3'd0, 1'b0, 1'b0, 1'b0, 1'b0, 16'sh1234}, 1'b0, '0},
      // second arm edge while gating: wait to go idle
      '{'{3'd0, 1'b0, 1'b0, 1'b1, 1'b0, 16'sh8000}, 1'b0, '0},
      '{'{3'd0, 1'b0, 1'b0, 1'b0, 1'b0, 16'sh7FFF}, 1'b0, '0},
      // arm edge while waiting cancels the pending change
      '{'{3'd0, 1'b0, 1'b0, 1'b1, 1'b0, 16'shFFFF}, 1'b0, '0},
      '{'{3'd0, 1'b0, 1'b0, 1'b0, 1'b0, 16'sh0001}, 1'b0, '0},
      '{'{3'd0, 1'b0, 1'b0, 1'b1, 1'b0, 16'sh0000}, 1'b0, '0},
      // clock edge: leave gating, level drops at once
      '{'{3'd0, 1'b1, 1'b0, 1'b1, 1'b0, 16'sh0000}, 1'b0, '0},
      // later slot of the same frame still sees that clock edge
      '{'{3'd1, 1'b0, 1'b0, 1'b1, 1'b0, 16'sh4000}, 1'b0, '0},
      // channel reset edge forces idle
      '{'{3'd1, 1'b0, 1'b0, 1'b1, 1'b1, 16'sh4000}, 1'b0, '0},
      // reset-all edge on the frame start
      '{'{3'd0, 1'b0, 1'b1, 1'b0, 1'b0, 16'sh0000}, 1'b0, '0},
      '{'{3'd1, 1'b0, 1'b1, 1'b0, 1'b0, 16'sh0000}, 1'b0, '0},
      // from here: four-tick fade, unarm disabled, inputs connected
      '{'{3'd0, 1'b0, 1'b0, 1'b1, 1'b0, 16'sh7FFF}, 1'b0, '0},
      '{'{3'd0, 1'b0, 1'b0, 1'b0, 1'b0, 16'sh7FFF}, 1'b0, '0},
      // second arm edge no longer cancels
      '{'{3'd0, 1'b0, 1'b0, 1'b1, 1'b0, 16'sh7FFF}, 1'b0, '0},
      // rise starts on the clock edge
      '{'{3'd0, 1'b1, 1'b0, 1'b0, 1'b0, 16'sh8000}, 1'b0, '0},
      '{'{3'd0, 1'b0, 1'b0, 1'b0, 1'b0, 16'sh7FFF}, 1'b0, '0},
      '{'{3'd0, 1'b0, 1'b0, 1'b0, 1'b0, 16'shFFFF}, 1'b0, '0},
      '{'{3'd0, 1'b0, 1'b0, 1'b0, 1'b0, 16'sh7FFF}, 1'b0, '0},
      '{'{3'd0, 1'b0, 1'b0, 1'b1, 1'b0, 16'sh8000}, 1'b0, '0},
      '{'{3'd0, 1'b0, 1'b0, 1'b0, 1'b0, 16'sh8000}, 1'b0, '0},
      // fall starts on the clock edge
      '{'{3'd0, 1'b1, 1'b0, 1'b0, 1'b0, 16'sh8000}, 1'b0, '0},
      // last channel: arm and reset edges together, reset wins first
      '{'{3'd7, 1'b1, 1'b0, 1'b1, 1'b1, 16'sh8000}, 1'b0, '0}
   };

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin
      req_type          item;
      logic             clk_lvl;
      logic             rsa_lvl;
      logic [CHANNELS-1:0] arm_lvl;
      int               phase_goal;
      logic [TICKS_W-1:0] fade;
      logic             unarm;
      logic [MASK_W-1:0] mask;

      clk_lvl = 1'b0;
      rsa_lvl = 1'b0;
      arm_lvl = '0;

      // hold reset, then release it on a falling edge
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         if (i == DIRECTED_SPLIT) program_csr(24'd4, 1'b1, 8'hFF);
         offer(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
      end

      // Random phases: each picks register values (extremes first) and one
      // idle pattern, then streams well-formed frames and noise slots with random levels.
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            0: begin
               fade = '0; unarm = 1'b0; mask = '1;
            end
            1: begin
               fade = 24'd1; unarm = 1'b1; mask = MASK_W'($urandom);
            end
            2: begin
               fade = '1; unarm = 1'b0; mask = '0;
            end
            3: begin
               fade = TICKS_W'($urandom_range(2, 12)); unarm = 1'b1;
               mask = MASK_W'($urandom);
            end
            default: begin
               fade  = coin(25) ? '0 : TICKS_W'($urandom_range(1, 30));
               unarm = coin(50);
               mask  = MASK_W'($urandom);
            end
         endcase
         program_csr(fade, unarm, mask);

         // idle pattern: none, sender, receiver, then both lightly
         case (p % 4)
            0: begin
               send_gap_pct = 0;  stall_pct = 0;
            end
            1: begin
               send_gap_pct = 83; stall_pct = 0;
            end
            2: begin
               send_gap_pct = 0;  stall_pct = 83;
            end
            default: begin
               send_gap_pct = 10; stall_pct = 10;
            end
         endcase

         phase_goal = sent_count + ITEMS_PER_PHASE;
         while (sent_count < phase_goal) begin
            if (coin(10)) begin
               // noise: slots out of order with arbitrary levels
               repeat ($urandom_range(1, 3)) begin
                  item.channel         = CH_W'($urandom_range(0, CHANNELS - 1));
                  item.clock_level     = 1'($urandom);
                  item.reset_all_level = 1'($urandom);
                  item.arm_level       = 1'($urandom);
                  item.reset_level     = 1'($urandom);
                  item.in_sample       = pick_sample();
                  offer(item, 1'b0, '0);
               end
            end else begin
               // one well-formed frame, channel 0 first
               if (coin(50)) clk_lvl = !clk_lvl;
               rsa_lvl = coin(4);
               for (int c = 0; c < CHANNELS; c++) begin
                  if (coin(30)) arm_lvl[CH_IDX_W'(c)] = !arm_lvl[CH_IDX_W'(c)];
                  item.channel         = CH_W'(c);
                  item.clock_level     = clk_lvl;
                  item.reset_all_level = rsa_lvl;
                  item.arm_level       = arm_lvl[CH_IDX_W'(c)];
                  item.reset_level     = coin(3);
                  item.in_sample       = pick_sample();
                  offer(item, 1'b0, '0);
               end
            end
         end
      end

      // drain and let the last transaction clear the pipeline
      settle();
      $display("Sent %0d transactions (directed table plus %0d random register/idle phases);",
               sent_count, RANDOM_PHASES);
      $display("checked %0d results, %0d failures.", results_checked, failures);
      if (failures == 0) begin
         $display("** clock_synced_gate_toggle_with_fade: PASSED **");
      end else begin
         $display("** clock_synced_gate_toggle_with_fade: FAILED **");
      end
      $finish;
   end

   // watchdog: a hung handshake ends the run as a failure
   initial begin
      #(WATCHDOG_TIME);
      $display("%0t: timeout, %0d results still expected", $time, expected_results.size());
      $display("** clock_synced_gate_toggle_with_fade: FAILED **");
      $finish;
   end

endmodule

`default_nettype wire
